[hdl/sgdm_pkg.sv]
// ----------------------------------------------------------------------------
// sgdm_pkg
// shared types, constants and helpers for the sgd momentum update block
// ----------------------------------------------------------------------------
package sgdm_pkg;

    localparam int WEIGHT_COUNT_DEF = 1024;
    localparam int IDX_W            = 10;
    localparam int DATA_W           = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 17;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

    // configuration reset values
    localparam logic [15:0] MOMENTUM_RST      = 16'd29491;
    localparam logic [15:0] LEARNING_RATE_RST = 16'd655;
    localparam logic [16:0] INVERSE_BATCH_RST = 17'd65536;
    localparam logic [15:0] DEAD_ZONE_RST     = 16'd0;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOMENTUM      = 2'd0,
        CFG_LEARNING_RATE = 2'd1,
        CFG_INVERSE_BATCH = 2'd2,
        CFG_DEAD_ZONE     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] momentum;
        logic [15:0] learning_rate;
        logic [16:0] inverse_batch;
        logic [15:0] dead_zone;
    } t_cfg;

    // per-item bookkeeping that travels with the item down the pipeline
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] weight;
        logic                     err;     // batch size zero
        logic                     stored;  // index lies inside the velocity store
    } t_tag;

    typedef struct packed {
        t_tag                     tag;
        logic signed [DATA_W-1:0] grad;
    } t_item;

    // saturate a 35-bit signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [34:0] x);
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        hi = {{3{SAT_MAX[DATA_W-1]}}, SAT_MAX};
        lo = {{3{SAT_MIN[DATA_W-1]}}, SAT_MIN};
        if (x > hi) begin
            return SAT_MAX;
        end else if (x < lo) begin
            return SAT_MIN;
        end else begin
            return x[DATA_W-1:0];
        end
    endfunction

endpackage

[hdl/sgdm_front.sv]
// ----------------------------------------------------------------------------
// sgdm_front
// accepts input transactions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module sgdm_front #(
    parameter int WEIGHT_COUNT = sgdm_pkg::WEIGHT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sgdm_pkg::IDX_W-1:0]          i_weight_index,
    input  logic signed [sgdm_pkg::DATA_W-1:0]  i_gradient_sum,
    input  logic signed [sgdm_pkg::DATA_W-1:0]  i_weight_in,
    input  sgdm_pkg::t_cfg                      i_cfg,
    input  logic                                i_block,
    output sgdm_pkg::t_item                     o_head,
    output logic                                o_head_valid,
    input  logic                                i_pop
);
    import sgdm_pkg::*;

    t_item                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;
    logic [QUEUE_AW:0]    n_count;
    logic                 w_push;
    t_item                w_item;

    assign o_ready      = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH)) && !i_block;
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    // classify: batch size zero, index inside the store
    always_comb begin
        w_item.grad       = i_gradient_sum;
        w_item.tag.idx    = i_weight_index;
        w_item.tag.weight = i_weight_in;
        w_item.tag.err    = (i_cfg.inverse_batch == '0);
        w_item.tag.stored = ({22'd0, i_weight_index} < 32'(WEIGHT_COUNT));
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

[hdl/sgdm_back.sv]
// ----------------------------------------------------------------------------
// sgdm_back
// velocity store and update pipeline, issues items from the queue head
// ----------------------------------------------------------------------------
module sgdm_back #(
    parameter int WEIGHT_COUNT = sgdm_pkg::WEIGHT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sgdm_pkg::t_cfg                      i_cfg,
    input  sgdm_pkg::t_item                     i_head,
    input  logic                                i_head_valid,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [sgdm_pkg::DATA_W-1:0]  o_weight_out,
    output logic [sgdm_pkg::IDX_W-1:0]          o_index_out,
    output logic                                o_error
);
    import sgdm_pkg::*;

    localparam int DEPTH = (WEIGHT_COUNT < (1 << IDX_W)) ? WEIGHT_COUNT : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_out_v;
    t_tag r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;

    logic signed [DATA_W-1:0] r_s1_grad;
    logic signed [48:0]       r_s2_prod_avg;
    logic signed [47:0]       r_s2_prod_dec;
    logic signed [DATA_W-1:0] r_s3_avg;
    logic signed [32:0]       r_s3_decayed;
    logic signed [32:0]       r_s4_decayed;
    logic signed [DATA_W-1:0] r_s4_step;
    logic signed [DATA_W-1:0] r_s5_vnew;

    logic signed [DATA_W-1:0] r_out_weight;
    logic [IDX_W-1:0]         r_out_idx;
    logic                     r_out_err;

    logic                     w_en;
    logic                     w_hazard;
    logic                     w_issue;
    logic signed [DATA_W-1:0] w_vold;
    logic signed [48:0]       w_prod_avg;
    logic signed [47:0]       w_prod_dec;
    logic signed [32:0]       w_avg_sh;
    logic signed [47:0]       w_prod_step;
    logic signed [34:0]       w_diff;
    logic signed [DATA_W-1:0] w_vnew;
    logic                     w_wr;
    logic [32:0]              w_mag;
    logic signed [DATA_W-1:0] w_sum;
    logic signed [DATA_W-1:0] w_result;

    // whole pipeline advances together when the output register is free
    assign w_en = !r_out_v || i_ready;

    // a velocity read must wait for any pending write to the same entry
    always_comb begin
        w_hazard = 1'b0;
        if (r_s1_v && r_s1_tag.stored && !r_s1_tag.err && r_s1_tag.idx == i_head.tag.idx)
            w_hazard = 1'b1;
        if (r_s2_v && r_s2_tag.stored && !r_s2_tag.err && r_s2_tag.idx == i_head.tag.idx)
            w_hazard = 1'b1;
        if (r_s3_v && r_s3_tag.stored && !r_s3_tag.err && r_s3_tag.idx == i_head.tag.idx)
            w_hazard = 1'b1;
        if (r_s4_v && r_s4_tag.stored && !r_s4_tag.err && r_s4_tag.idx == i_head.tag.idx)
            w_hazard = 1'b1;
    end

    assign w_issue    = w_en && i_head_valid && !w_hazard && !r_clr_busy;
    assign o_pop      = w_issue;
    assign o_clearing = r_clr_busy;

    // stage 1: average and decay products
    assign w_vold     = r_s1_tag.stored ? r_rd_data : '0;
    assign w_prod_avg = r_s1_grad * $signed({1'b0, i_cfg.inverse_batch});
    assign w_prod_dec = w_vold * $signed({1'b0, i_cfg.momentum});

    // stage 2: saturate average
    assign w_avg_sh   = r_s2_prod_avg[48:16];

    // stage 3: learning rate product
    assign w_prod_step = r_s3_avg * $signed({1'b0, i_cfg.learning_rate});

    // stage 4: new velocity
    assign w_diff = $signed({{2{r_s4_decayed[32]}}, r_s4_decayed})
                  - $signed({{3{r_s4_step[DATA_W-1]}}, r_s4_step});
    assign w_vnew = sat32(w_diff);
    assign w_wr   = w_en && r_s4_v && r_s4_tag.stored && !r_s4_tag.err;

    // stage 5: dead zone and weight add
    assign w_mag = r_s5_vnew[DATA_W-1] ? (33'd0 - {r_s5_vnew[DATA_W-1], r_s5_vnew})
                                       : {1'b0, r_s5_vnew};
    assign w_sum = sat32($signed({{3{r_s5_tag.weight[DATA_W-1]}}, r_s5_tag.weight})
                       + $signed({{3{r_s5_vnew[DATA_W-1]}}, r_s5_vnew}));
    assign w_result = (!r_s5_tag.err && (w_mag > {17'd0, i_cfg.dead_zone})) ? w_sum
                                                                          : r_s5_tag.weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_s4_v     <= 1'b0;
            r_s5_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_en) begin
                r_s1_v  <= w_issue;
                r_s2_v  <= r_s1_v;
                r_s3_v  <= r_s2_v;
                r_s4_v  <= r_s3_v;
                r_s5_v  <= r_s4_v;
                r_out_v <= r_s5_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_tag      <= i_head.tag;
            r_s1_grad     <= i_head.grad;
            r_s2_tag      <= r_s1_tag;
            r_s2_prod_avg <= w_prod_avg;
            r_s2_prod_dec <= w_prod_dec;
            r_s3_tag      <= r_s2_tag;
            r_s3_avg      <= sat32($signed({{2{w_avg_sh[32]}}, w_avg_sh}));
            r_s3_decayed  <= r_s2_prod_dec[47:15];
            r_s4_tag      <= r_s3_tag;
            r_s4_decayed  <= r_s3_decayed;
            r_s4_step     <= w_prod_step[47:16];
            r_s5_tag      <= r_s4_tag;
            r_s5_vnew     <= w_vnew;
            r_out_weight  <= w_result;
            r_out_idx     <= r_s5_tag.idx;
            r_out_err     <= r_s5_tag.err;
        end
    end

    // velocity store: one write port (clear or update), one registered read
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (w_wr) begin
            r_mem[r_s4_tag.idx[AW-1:0]] <= w_vnew;
        end
        if (w_en) begin
            r_rd_data <= r_mem[i_head.tag.idx[AW-1:0]];
        end
    end

    assign o_valid      = r_out_v;
    assign o_weight_out = r_out_weight;
    assign o_index_out  = r_out_idx;
    assign o_error      = r_out_err;

endmodule

[hdl/sgd_momentum_update.sv]
// ----------------------------------------------------------------------------
// sgd_momentum_update
// sgd with momentum weight update, one weight per transaction, Q16.16
// ----------------------------------------------------------------------------
// Takes one weight update transaction per clock when nothing stalls it and
// returns one result per transaction in order. A front queue of four entries
// takes transactions while the update pipeline or the output is stalled. The
// pipeline has five stages after issue plus the output register. Sustained
// rate is one transaction per cycle while i_ready stays high; the exception is
// a transaction whose weight index matches a velocity update still in the four
// stages before the velocity write, which waits at the queue head until that
// write lands. After reset the velocity store is cleared one entry per cycle,
// all min(WEIGHT_COUNT, 1024) entries, during which o_ready is low;
// configuration writes are taken at any time but should only be made while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module sgd_momentum_update #(
    parameter int WEIGHT_COUNT = sgdm_pkg::WEIGHT_COUNT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input transactions
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [sgdm_pkg::IDX_W-1:0]             i_weight_index,
    input  logic signed [sgdm_pkg::DATA_W-1:0]     i_gradient_sum,
    input  logic signed [sgdm_pkg::DATA_W-1:0]     i_weight_in,
    // result transactions
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [sgdm_pkg::DATA_W-1:0]     o_weight_out,
    output logic [sgdm_pkg::IDX_W-1:0]             o_index_out,
    output logic                                   o_error,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sgdm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sgdm_pkg::*;

    t_cfg  r_cfg;
    t_item w_head;
    logic  w_head_valid;
    logic  w_pop;
    logic  w_clearing;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // config registers, data truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.momentum      <= MOMENTUM_RST;
            r_cfg.learning_rate <= LEARNING_RATE_RST;
            r_cfg.inverse_batch <= INVERSE_BATCH_RST;
            r_cfg.dead_zone     <= DEAD_ZONE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MOMENTUM:      r_cfg.momentum      <= i_cfg_data[15:0];
                CFG_LEARNING_RATE: r_cfg.learning_rate <= i_cfg_data[15:0];
                CFG_INVERSE_BATCH: r_cfg.inverse_batch <= i_cfg_data[16:0];
                CFG_DEAD_ZONE:     r_cfg.dead_zone     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept, classify, queue
    sgdm_front #(
        .WEIGHT_COUNT (WEIGHT_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_weight_index (i_weight_index),
        .i_gradient_sum (i_gradient_sum),
        .i_weight_in    (i_weight_in),
        .i_cfg          (r_cfg),
        .i_block        (w_clearing),
        .o_head         (w_head),
        .o_head_valid   (w_head_valid),
        .i_pop          (w_pop)
    );

    // back: velocity store, update pipeline, output register
    sgdm_back #(
        .WEIGHT_COUNT (WEIGHT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_weight_out (o_weight_out),
        .o_index_out  (o_index_out),
        .o_error      (o_error)
    );

endmodule

[hdl/sgdm_checker.sv]
// ----------------------------------------------------------------------------
// sgdm_checker
// port level checks for the sgd momentum update block, bound to the top level
// ----------------------------------------------------------------------------
module sgdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_weight_out,
    input logic [9:0]  o_index_out,
    input logic        o_error
);
    logic [7:0] r_pending;

    // transactions taken but not yet returned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 8'(i_valid && o_ready) - 8'(o_valid && i_ready);
        end
    end

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 8'd0)
        else $error("result without a pending transaction");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_clear_pass_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input ready during velocity clear");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_weight_out)
                                && $stable(o_index_out) && $stable(o_error))
        else $error("stalled result changed");

endmodule

bind sgd_momentum_update sgdm_checker u_sgdm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_weight_out (o_weight_out),
    .o_index_out  (o_index_out),
    .o_error      (o_error)
);
